// ----- hdl/lpsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lpsc_pkg;

   localparam logic [1:0] REQ_LOOKUP  = 2'd0;
   localparam logic [1:0] REQ_COMMIT  = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   localparam logic [2:0] ST_HIT   = 3'd0;
   localparam logic [2:0] ST_FREE  = 3'd1;
   localparam logic [2:0] ST_EVICT = 3'd2;
   localparam logic [2:0] ST_NONE  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [6:0] ACTIVE_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_COMMIT,
      OP_RELEASE,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] key;
      logic [5:0]  sn;
   } entry_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_META_W,
      B_SCAN,
      B_DECIDE,
      B_POP_W
   } back_state_type;

   typedef enum logic [1:0] {
      UPD_TOUCH,
      UPD_DROP,
      UPD_INSERT
   } upd_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } back_stat_type;

endpackage
`default_nettype wire

// ----- hdl/lru_page_slot_cache_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Page residency cache with LRU replacement over SLOTS slots and a LIFO free stack.
// An item is accepted when start is high and busy is low; its one result appears on
// the rsp_ ports for exactly one cycle with rsp_strobe high, and the receiver cannot
// stall it. A two-entry queue takes items while the back end works. The back end walks
// the key and rank memories one slot per cycle: a lookup that hits or evicts makes a
// search walk, then a rank-update walk; a lookup that takes a free slot or finds no
// slot makes only the search walk; a commit, or a release of a resident slot, makes one
// rank-update walk; other items need no walk. After reset and after every csr write a
// clearing pass over all SLOTS slots runs, during which busy is high.
module lru_page_slot_cache_top #(
   parameter int SLOTS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_type,
   input  wire  [63:0] req_page_key,
   input  wire  [5:0]  req_slot_number,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot_out,
   output logic [63:0] rsp_evicted_key,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [6:0]  csr_wdata
);
   lpsc_pkg::back_stat_type stat;
   lpsc_pkg::entry_type     q_entry;
   logic q_valid, q_pop, q_empty;

   assign csr_ready = stat.idle && q_empty;

   lpsc_front #(.SLOTS(SLOTS)) u_front (
      .clock, .reset, .start, .busy, .req_type, .req_page_key, .req_slot_number,
      .stat, .q_valid, .q_entry, .q_pop, .q_empty
   );

   lpsc_back #(.SLOTS(SLOTS)) u_back (
      .clock, .reset,
      .cfg_we(csr_valid && csr_ready), .cfg_data(csr_wdata),
      .q_valid, .q_entry, .q_pop, .stat,
      .rsp_strobe, .rsp_status, .rsp_slot_out, .rsp_evicted_key
   );
endmodule
`default_nettype wire

// ----- hdl/lpsc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lpsc_front #(
   parameter int SLOTS = 64
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire  [1:0]                req_type,
   input  wire  [63:0]               req_page_key,
   input  wire  [5:0]                req_slot_number,
   input  lpsc_pkg::back_stat_type   stat,
   output logic                      q_valid,
   output lpsc_pkg::entry_type       q_entry,
   input  wire                       q_pop,
   output logic                      q_empty
);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SW = (SLOT_W > 6) ? SLOT_W + 1 : 7;

   lpsc_pkg::entry_type mem_ff [2];
   lpsc_pkg::entry_type cls;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, in_range;

   assign in_range = SW'(req_slot_number) < SW'(SLOTS);
   assign busy     = (cnt_ff == 2'd2) || stat.clearing;
   assign push     = start && !busy;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_empty  = cnt_ff == 2'd0;
   assign q_entry  = mem_ff[rd_ff];

   always_comb begin
      cls.key = req_page_key;
      cls.sn  = req_slot_number;
      unique case (req_type)
         lpsc_pkg::REQ_LOOKUP:  cls.op = lpsc_pkg::OP_LOOKUP;
         lpsc_pkg::REQ_COMMIT:  cls.op = in_range ? lpsc_pkg::OP_COMMIT : lpsc_pkg::OP_BAD;
         lpsc_pkg::REQ_RELEASE: cls.op = in_range ? lpsc_pkg::OP_RELEASE : lpsc_pkg::OP_BAD;
         default:               cls.op = lpsc_pkg::OP_BAD;
      endcase
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = q_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= cls;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/lpsc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lpsc_back #(
   parameter int SLOTS = 64
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       cfg_we,
   input  wire  [6:0]                cfg_data,
   input  wire                       q_valid,
   input  lpsc_pkg::entry_type       q_entry,
   output logic                      q_pop,
   output lpsc_pkg::back_stat_type   stat,
   output logic                      rsp_strobe,
   output logic [2:0]                rsp_status,
   output logic [5:0]                rsp_slot_out,
   output logic [63:0]               rsp_evicted_key
);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int AW     = (CNT_W > 7) ? CNT_W : 7;
   localparam int SW     = (SLOT_W > 6) ? SLOT_W : 6;

   logic [63:0]     key_mem   [SLOTS];
   logic [SLOT_W:0] meta_mem  [SLOTS];
   logic [SLOT_W-1:0] stack_mem [SLOTS];

   lpsc_pkg::back_state_type state_ff, state_in;
   lpsc_pkg::entry_type      op_ff, op_in;
   lpsc_pkg::upd_type        upd_ff, upd_in;
   logic [6:0]        active_ff, active_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, free_count_ff, free_count_in, n_act, fc_m1;
   logic [SLOT_W-1:0] idxd_ff, idxd_in, tgt_ff, tgt_in, r_ff, r_in;
   logic [SLOT_W-1:0] best_ff, best_in, bestrank_ff, bestrank_in;
   logic [SLOT_W-1:0] old_ff, old_in, oldrank_ff, oldrank_in;
   logic [63:0]       oldkey_ff, oldkey_in;
   logic              pend_ff, pend_in, search_ff, search_in, rs_ff, rs_in;
   logic              found_ff, found_in, any_ff, any_in;
   logic [2:0]        res_status_ff, res_status_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [63:0]       res_ekey_ff, res_ekey_in;
   logic              rsp_valid_in;
   logic [2:0]        rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [63:0]       rsp_ekey_in;

   logic [63:0]       key_rd_ff;
   logic [SLOT_W:0]   meta_rd_ff;
   logic [SLOT_W-1:0] stack_rd_ff;
   logic [SLOT_W-1:0] meta_raddr, key_raddr, stack_raddr;
   logic              meta_we, key_we, stack_we;
   logic [SLOT_W-1:0] meta_waddr, key_waddr, stack_waddr, stack_wdata;
   logic [SLOT_W:0]   meta_wdata;
   logic [63:0]       key_wdata;
   logic [SW-1:0]     qsn_ext, osn_ext, slot_ext;
   logic              m_res;
   logic [SLOT_W-1:0] m_rank;

   assign n_act = (AW'(active_ff) > AW'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(active_ff);
   assign fc_m1 = free_count_ff - 1'b1;
   assign qsn_ext = SW'(q_entry.sn);
   assign osn_ext = SW'(op_ff.sn);
   assign m_res  = meta_rd_ff[SLOT_W];
   assign m_rank = meta_rd_ff[SLOT_W-1:0];
   assign slot_ext = SW'(rsp_slot_ff);
   assign rsp_slot_out = slot_ext[5:0];
   assign stat.clearing = state_ff == lpsc_pkg::B_CLEAR;
   assign stat.idle     = (state_ff == lpsc_pkg::B_IDLE) && !rsp_strobe;

   always_comb begin
      state_in = state_ff;  op_in = op_ff;  upd_in = upd_ff;
      active_in = active_ff;  idx_in = idx_ff;  free_count_in = free_count_ff;
      idxd_in = idxd_ff;  tgt_in = tgt_ff;  r_in = r_ff;  rs_in = rs_ff;
      best_in = best_ff;  bestrank_in = bestrank_ff;  found_in = found_ff;
      old_in = old_ff;  oldrank_in = oldrank_ff;  oldkey_in = oldkey_ff;  any_in = any_ff;
      pend_in = 1'b0;  search_in = search_ff;
      res_status_in = res_status_ff;  res_slot_in = res_slot_ff;  res_ekey_in = res_ekey_ff;
      rsp_valid_in = 1'b0;  rsp_status_in = rsp_status;  rsp_slot_in = rsp_slot_ff;
      rsp_ekey_in = rsp_evicted_key;
      q_pop = 1'b0;
      meta_raddr = idx_ff[SLOT_W-1:0];  key_raddr = idx_ff[SLOT_W-1:0];
      stack_raddr = fc_m1[SLOT_W-1:0];
      meta_we = 1'b0;  meta_waddr = idxd_ff;  meta_wdata = meta_rd_ff;
      key_we = 1'b0;  key_waddr = osn_ext[SLOT_W-1:0];  key_wdata = op_ff.key;
      stack_we = 1'b0;  stack_waddr = free_count_ff[SLOT_W-1:0];  stack_wdata = tgt_ff;

      unique case (state_ff)
         lpsc_pkg::B_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = idx_ff[SLOT_W-1:0];
            meta_wdata = '0;
            if (idx_ff < n_act) begin
               stack_we    = 1'b1;
               stack_waddr = idx_ff[SLOT_W-1:0];
               stack_wdata = SLOT_W'(n_act - idx_ff - 1'b1);
            end
            if (idx_ff == CNT_W'(SLOTS - 1)) begin
               free_count_in = n_act;
               state_in      = lpsc_pkg::B_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         lpsc_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               op_in = q_entry;
               case (q_entry.op)
                  lpsc_pkg::OP_LOOKUP: begin
                     state_in  = lpsc_pkg::B_SCAN;
                     search_in = 1'b1;
                     idx_in    = '0;
                     found_in  = 1'b0;
                     any_in    = 1'b0;
                  end
                  lpsc_pkg::OP_COMMIT, lpsc_pkg::OP_RELEASE: begin
                     meta_raddr = qsn_ext[SLOT_W-1:0];
                     state_in   = lpsc_pkg::B_META_W;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = lpsc_pkg::ST_NONE;
                     rsp_slot_in   = '0;
                     rsp_ekey_in   = '0;
                  end
               endcase
            end
         end
         lpsc_pkg::B_META_W: begin
            rs_in  = m_res;
            r_in   = m_rank;
            tgt_in = osn_ext[SLOT_W-1:0];
            res_status_in = lpsc_pkg::ST_DONE;
            res_slot_in   = '0;
            res_ekey_in   = '0;
            idx_in    = '0;
            search_in = 1'b0;
            if (op_ff.op == lpsc_pkg::OP_COMMIT) begin
               key_we   = 1'b1;
               upd_in   = lpsc_pkg::UPD_INSERT;
               state_in = lpsc_pkg::B_SCAN;
            end else begin
               if (free_count_ff != CNT_W'(SLOTS)) begin
                  stack_we      = 1'b1;
                  stack_wdata   = osn_ext[SLOT_W-1:0];
                  free_count_in = free_count_ff + 1'b1;
               end
               if (m_res) begin
                  upd_in   = lpsc_pkg::UPD_DROP;
                  state_in = lpsc_pkg::B_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = lpsc_pkg::ST_DONE;
                  rsp_slot_in   = '0;
                  rsp_ekey_in   = '0;
                  state_in      = lpsc_pkg::B_IDLE;
               end
            end
         end
         lpsc_pkg::B_SCAN: begin
            if (idx_ff != CNT_W'(SLOTS)) begin
               idx_in  = idx_ff + 1'b1;
               idxd_in = idx_ff[SLOT_W-1:0];
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (search_ff) begin
                  // Ranks of resident slots are distinct, so ties cannot occur.
                  if (m_res && key_rd_ff == op_ff.key && (!found_ff || m_rank < bestrank_ff)) begin
                     found_in = 1'b1;  best_in = idxd_ff;  bestrank_in = m_rank;
                  end
                  if (m_res && (!any_ff || m_rank > oldrank_ff)) begin
                     any_in = 1'b1;  old_in = idxd_ff;  oldrank_in = m_rank;
                     oldkey_in = key_rd_ff;
                  end
               end else begin
                  meta_we = 1'b1;
                  case (upd_ff)
                     lpsc_pkg::UPD_TOUCH: begin
                        if (idxd_ff == tgt_ff) meta_wdata = {1'b1, {SLOT_W{1'b0}}};
                        else if (m_res && m_rank < r_ff)
                           meta_wdata = {1'b1, SLOT_W'(m_rank + 1'b1)};
                     end
                     lpsc_pkg::UPD_DROP: begin
                        if (idxd_ff == tgt_ff) meta_wdata = '0;
                        else if (m_res && m_rank > r_ff)
                           meta_wdata = {1'b1, SLOT_W'(m_rank - 1'b1)};
                     end
                     default: begin
                        // A re-commit closes the old gap and opens rank zero in one pass.
                        if (idxd_ff == tgt_ff) meta_wdata = {1'b1, {SLOT_W{1'b0}}};
                        else if (m_res && (!rs_ff || m_rank < r_ff))
                           meta_wdata = {1'b1, SLOT_W'(m_rank + 1'b1)};
                     end
                  endcase
               end
               if (idx_ff == CNT_W'(SLOTS)) begin
                  if (search_ff) begin
                     state_in = lpsc_pkg::B_DECIDE;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = res_status_ff;
                     rsp_slot_in   = res_slot_ff;
                     rsp_ekey_in   = res_ekey_ff;
                     state_in      = lpsc_pkg::B_IDLE;
                  end
               end
            end
         end
         lpsc_pkg::B_DECIDE: begin
            idx_in    = '0;
            search_in = 1'b0;
            if (found_ff) begin
               upd_in = lpsc_pkg::UPD_TOUCH;  tgt_in = best_ff;  r_in = bestrank_ff;
               res_status_in = lpsc_pkg::ST_HIT;  res_slot_in = best_ff;  res_ekey_in = '0;
               state_in = lpsc_pkg::B_SCAN;
            end else if (free_count_ff != '0) begin
               free_count_in = fc_m1;
               state_in      = lpsc_pkg::B_POP_W;
            end else if (any_ff) begin
               upd_in = lpsc_pkg::UPD_DROP;  tgt_in = old_ff;  r_in = oldrank_ff;
               res_status_in = lpsc_pkg::ST_EVICT;  res_slot_in = old_ff;
               res_ekey_in = oldkey_ff;
               state_in = lpsc_pkg::B_SCAN;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = lpsc_pkg::ST_NONE;
               rsp_slot_in   = '0;
               rsp_ekey_in   = '0;
               state_in      = lpsc_pkg::B_IDLE;
            end
         end
         lpsc_pkg::B_POP_W: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = lpsc_pkg::ST_FREE;
            rsp_slot_in   = stack_rd_ff;
            rsp_ekey_in   = '0;
            state_in      = lpsc_pkg::B_IDLE;
         end
         default: state_in = lpsc_pkg::B_IDLE;
      endcase

      if (cfg_we) begin
         active_in = cfg_data;
         idx_in    = '0;
         state_in  = lpsc_pkg::B_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lpsc_pkg::B_CLEAR;
         active_ff     <= lpsc_pkg::ACTIVE_RESET;
         idx_ff        <= '0;
         free_count_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         idx_ff        <= idx_in;
         free_count_ff <= free_count_in;
         pend_ff       <= pend_in;
         rsp_strobe    <= rsp_valid_in;
      end
      op_ff <= op_in;  upd_ff <= upd_in;  idxd_ff <= idxd_in;  tgt_ff <= tgt_in;
      r_ff <= r_in;  rs_ff <= rs_in;  search_ff <= search_in;
      best_ff <= best_in;  bestrank_ff <= bestrank_in;  found_ff <= found_in;
      old_ff <= old_in;  oldrank_ff <= oldrank_in;  oldkey_ff <= oldkey_in;  any_ff <= any_in;
      res_status_ff <= res_status_in;  res_slot_ff <= res_slot_in;  res_ekey_ff <= res_ekey_in;
      rsp_status <= rsp_status_in;  rsp_slot_ff <= rsp_slot_in;  rsp_evicted_key <= rsp_ekey_in;
   end

   always_ff @(posedge clock) begin
      key_rd_ff   <= key_mem[key_raddr];
      meta_rd_ff  <= meta_mem[meta_raddr];
      stack_rd_ff <= stack_mem[stack_raddr];
      if (key_we) key_mem[key_waddr] <= key_wdata;
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
   end

`ifndef NO_ASSERTIONS
   a_fc_range: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(SLOTS)) else $error("free count above slot count");
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(q_pop) || $past(state_ff) != lpsc_pkg::B_IDLE)
      else $error("result without work");
   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == lpsc_pkg::B_SCAN) else $error("read data outside scan");
`endif
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [63:0] ekey;
   } page_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_type = lpsc_pkg::REQ_LOOKUP;
   logic [63:0] req_page_key = '0;
   logic [5:0]  req_slot_number = '0;
   logic        csr_valid = 1'b0;
   logic [6:0]  csr_wdata = '0;
   wire         busy;
   wire         rsp_strobe;
   wire  [2:0]  rsp_status;
   wire  [5:0]  rsp_slot_out;
   wire  [63:0] rsp_evicted_key;
   wire         csr_ready;

   // Shadow copy of the residency table.
   logic [63:0] shadow_keys [64];
   logic        shadow_resident [64];
   int          shadow_rank [64];
   logic [5:0]  shadow_free [64];
   int          shadow_free_count;

   // Expected results in order of acceptance.
   page_answer_type answer_ring [64];
   int              ans_wr = 0;
   int              ans_rd = 0;
   logic [63:0]  key_pool [16];
   int           errors = 0;
   int           answers_seen = 0;
   int           hits = 0, free_takes = 0, evictions = 0, no_slots = 0, csr_writes = 0;

   lru_page_slot_cache_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_page_key(req_page_key), .req_slot_number(req_slot_number),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_slot_out(rsp_slot_out),
      .rsp_evicted_key(rsp_evicted_key),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #5000000;
      $display("timeout at %0t", $time);
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic shadow_clear(input int active);
      int n;
      n = active > 64 ? 64 : active;
      for (int i = 0; i < 64; i++) begin
         shadow_keys[i] = '0;
         shadow_resident[i] = 1'b0;
         shadow_rank[i] = 0;
         shadow_free[i] = '0;
      end
      for (int i = 0; i < n; i++) shadow_free[i] = 6'(n - 1 - i);
      shadow_free_count = n;
   endtask

   // Takes a slot out of the recency order; older ranks close up.
   task automatic shadow_drop(input int s);
      int r;
      r = shadow_rank[s];
      shadow_resident[s] = 1'b0;
      shadow_rank[s] = 0;
      for (int t = 0; t < 64; t++)
         if (shadow_resident[t] && shadow_rank[t] > r) shadow_rank[t]--;
   endtask

   task automatic shadow_step(input logic [1:0] op, input logic [63:0] key,
                              input logic [5:0] sn, output page_answer_type ans);
      int  best, old, r;
      bit  found;
      ans = '{status: lpsc_pkg::ST_NONE, slot: '0, ekey: '0};
      found = 0;
      best = 0;
      old = 0;
      case (op)
         lpsc_pkg::REQ_LOOKUP: begin
            for (int t = 0; t < 64; t++)
               if (shadow_resident[t] && shadow_keys[t] == key &&
                   (!found || shadow_rank[t] < shadow_rank[best])) begin
                  found = 1;
                  best = t;
               end
            if (found) begin
               r = shadow_rank[best];
               for (int t = 0; t < 64; t++)
                  if (shadow_resident[t] && shadow_rank[t] < r) shadow_rank[t]++;
               shadow_rank[best] = 0;
               ans.status = lpsc_pkg::ST_HIT;
               ans.slot = 6'(best);
            end else if (shadow_free_count > 0) begin
               shadow_free_count--;
               ans.status = lpsc_pkg::ST_FREE;
               ans.slot = shadow_free[shadow_free_count];
            end else begin
               for (int t = 0; t < 64; t++)
                  if (shadow_resident[t] && (!found || shadow_rank[t] > shadow_rank[old])) begin
                     found = 1;
                     old = t;
                  end
               if (found) begin
                  ans.ekey = shadow_keys[old];
                  shadow_drop(old);
                  ans.status = lpsc_pkg::ST_EVICT;
                  ans.slot = 6'(old);
               end
            end
         end
         lpsc_pkg::REQ_COMMIT: begin
            if (shadow_resident[sn]) shadow_drop(sn);
            shadow_keys[sn] = key;
            for (int t = 0; t < 64; t++)
               if (shadow_resident[t]) shadow_rank[t]++;
            shadow_resident[sn] = 1'b1;
            shadow_rank[sn] = 0;
            ans.status = lpsc_pkg::ST_DONE;
         end
         lpsc_pkg::REQ_RELEASE: begin
            if (shadow_resident[sn]) shadow_drop(sn);
            if (shadow_free_count < 64) begin
               shadow_free[shadow_free_count] = sn;
               shadow_free_count++;
            end
            ans.status = lpsc_pkg::ST_DONE;
         end
         default: ;
      endcase
   endtask

   task automatic post_answer(input page_answer_type ans);
      answer_ring[ans_wr % 64] = ans;
      ans_wr++;
   endtask

   // Leaves start high on return; the caller lowers it for a gap.
   task automatic send_item(input logic [1:0] op, input logic [63:0] key,
                            input logic [5:0] sn, output page_answer_type ans);
      start <= 1'b1;
      req_type <= op;
      req_page_key <= key;
      req_slot_number <= sn;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow_step(op, key, sn, ans);
      post_answer(ans);
   endtask

   task automatic sender_gap(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (ans_rd != ans_wr) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(input logic [6:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_clear(value);
      csr_writes++;
   endtask

   always @(posedge clock) begin
      page_answer_type exp_ans;
      if (!reset && rsp_strobe) begin
         answers_seen++;
         if (ans_rd == ans_wr) begin
            $display("%0t: unexpected result status=%0d slot=%0d key=%h",
                     $time, rsp_status, rsp_slot_out, rsp_evicted_key);
            errors++;
         end else begin
            exp_ans = answer_ring[ans_rd % 64];
            ans_rd++;
            if (rsp_status != exp_ans.status) begin
               $display("%0t: status expected %0d got %0d", $time, exp_ans.status, rsp_status);
               errors++;
            end
            if (rsp_slot_out != exp_ans.slot) begin
               $display("%0t: slot expected %0d got %0d", $time, exp_ans.slot, rsp_slot_out);
               errors++;
            end
            if (rsp_evicted_key != exp_ans.ekey) begin
               $display("%0t: evicted key expected %h got %h",
                        $time, exp_ans.ekey, rsp_evicted_key);
               errors++;
            end
            case (exp_ans.status)
               lpsc_pkg::ST_HIT:   hits++;
               lpsc_pkg::ST_FREE:  free_takes++;
               lpsc_pkg::ST_EVICT: evictions++;
               lpsc_pkg::ST_NONE:  no_slots++;
               default: ;
            endcase
         end
      end
   end

   task automatic test_directed;
      page_answer_type a;
      logic [63:0] k1, k2;
      k1 = 64'hA5A5_0F0F_1234_5678;
      k2 = 64'h5A5A_F0F0_EDCB_A987;
      send_item(lpsc_pkg::REQ_LOOKUP, 64'h0, 6'd0, a);
      send_item(lpsc_pkg::REQ_LOOKUP, '1, 6'd0, a);
      send_item(lpsc_pkg::REQ_COMMIT, 64'h0, 6'd0, a);
      send_item(lpsc_pkg::REQ_COMMIT, '1, 6'd63, a);
      send_item(lpsc_pkg::REQ_LOOKUP, '1, 6'd0, a);
      // Committing to a resident slot replaces its key.
      send_item(lpsc_pkg::REQ_COMMIT, k1, 6'd0, a);
      // The same key in two slots: the more recent one must hit.
      send_item(lpsc_pkg::REQ_COMMIT, k2, 6'd1, a);
      send_item(lpsc_pkg::REQ_COMMIT, k2, 6'd2, a);
      send_item(lpsc_pkg::REQ_LOOKUP, k2, 6'd0, a);
      send_item(lpsc_pkg::REQ_RELEASE, 64'h0, 6'd2, a);
      send_item(lpsc_pkg::REQ_LOOKUP, k2, 6'd0, a);
      send_item(2'(lpsc_pkg::OP_BAD), '1, '1, a);
      // Releasing resident slot 63 fills the free stack again; the next release finds it full.
      send_item(lpsc_pkg::REQ_RELEASE, 64'h0, 6'd63, a);
      send_item(lpsc_pkg::REQ_RELEASE, 64'h0, 6'd62, a);
      csr_write(7'd1);
      send_item(lpsc_pkg::REQ_LOOKUP, k1, 6'd0, a);
      send_item(lpsc_pkg::REQ_COMMIT, k1, a.slot, a);
      send_item(lpsc_pkg::REQ_LOOKUP, k2, 6'd0, a);
      send_item(lpsc_pkg::REQ_LOOKUP, k1, 6'd0, a);
      csr_write(7'd0);
      send_item(lpsc_pkg::REQ_LOOKUP, k1, 6'd0, a);
      send_item(lpsc_pkg::REQ_COMMIT, k1, 6'd5, a);
      send_item(lpsc_pkg::REQ_LOOKUP, k2, 6'd0, a);
      csr_write(7'd127);
      send_item(lpsc_pkg::REQ_LOOKUP, k1, 6'd0, a);
      send_item(lpsc_pkg::REQ_LOOKUP, k2, 6'd0, a);
      drain();
   endtask

   task automatic test_random(input int items, input int idle_pct);
      page_answer_type a;
      logic [63:0] key;
      logic [6:0]  cfg;
      int sent, r;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(5))
            0: cfg = 7'd1;
            1: cfg = 7'd64;
            2: cfg = 7'($urandom_range(65, 127));
            3: cfg = 7'($urandom_range(2, 8));
            default: cfg = 7'($urandom_range(0, 127));
         endcase
         csr_write(cfg);
         for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
         for (int j = 0; j < 130 && sent < items; j++) begin
            key = $urandom_range(9) < 8 ? key_pool[$urandom_range(15)] : {$urandom, $urandom};
            r = $urandom_range(99);
            if (r < 55) begin
               send_item(lpsc_pkg::REQ_LOOKUP, key, 6'($urandom), a);
               sent++;
               // Misses are mostly followed by filling the slot they got.
               if ((a.status == lpsc_pkg::ST_FREE || a.status == lpsc_pkg::ST_EVICT) &&
                   $urandom_range(9) < 8) begin
                  sender_gap(idle_pct);
                  send_item(lpsc_pkg::REQ_COMMIT, key, a.slot, a);
                  sent++;
               end
            end else if (r < 70) begin
               send_item(lpsc_pkg::REQ_COMMIT, key, 6'($urandom), a);
               sent++;
            end else if (r < 94) begin
               send_item(lpsc_pkg::REQ_RELEASE, {$urandom, $urandom}, 6'($urandom), a);
               sent++;
            end else begin
               send_item(2'(lpsc_pkg::OP_BAD), {$urandom, $urandom}, 6'($urandom), a);
               sent++;
            end
            sender_gap(idle_pct);
         end
      end
      drain();
   endtask

   initial begin
      shadow_clear(lpsc_pkg::ACTIVE_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(380, 37);
      test_random(380, 88);
      test_random(390, 0);
      $display("Covered %0d results: %0d hits, %0d free-slot misses, %0d evictions,",
               answers_seen, hits, free_takes, evictions);
      $display("%0d no-slot answers, over %0d active-slot register writes.",
               no_slots, csr_writes);
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hdl/lpsc_pkg.sv
hdl/lpsc_front.sv
hdl/lpsc_back.sv
hdl/lru_page_slot_cache_top.sv
tb/tb_top.sv
